/* src/rcod_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rcod_pkg;

   localparam int PIX_W   = 16;
   localparam int SIZE_W  = 11;
   localparam int BYTE_W  = 8;
   localparam int SUM_W   = 28;
   localparam int CNT_W   = 21;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd128;
   localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? 8'(a - b) : 8'(b - a);
   endfunction

   // 8x8 Bayer matrix entry, scaled by 4 to span the intensity range.
   function automatic logic [7:0] bayer_threshold(input logic [2:0] row3,
                                                  input logic [2:0] col3);
      logic [5:0] t;
      case ({row3, col3})
         6'o00: t = 6'd0;   6'o01: t = 6'd32;  6'o02: t = 6'd8;   6'o03: t = 6'd40;
         6'o04: t = 6'd2;   6'o05: t = 6'd34;  6'o06: t = 6'd10;  6'o07: t = 6'd42;
         6'o10: t = 6'd48;  6'o11: t = 6'd16;  6'o12: t = 6'd56;  6'o13: t = 6'd24;
         6'o14: t = 6'd50;  6'o15: t = 6'd18;  6'o16: t = 6'd58;  6'o17: t = 6'd26;
         6'o20: t = 6'd12;  6'o21: t = 6'd44;  6'o22: t = 6'd4;   6'o23: t = 6'd36;
         6'o24: t = 6'd14;  6'o25: t = 6'd46;  6'o26: t = 6'd6;   6'o27: t = 6'd38;
         6'o30: t = 6'd60;  6'o31: t = 6'd28;  6'o32: t = 6'd52;  6'o33: t = 6'd20;
         6'o34: t = 6'd62;  6'o35: t = 6'd30;  6'o36: t = 6'd54;  6'o37: t = 6'd22;
         6'o40: t = 6'd3;   6'o41: t = 6'd35;  6'o42: t = 6'd11;  6'o43: t = 6'd43;
         6'o44: t = 6'd1;   6'o45: t = 6'd33;  6'o46: t = 6'd9;   6'o47: t = 6'd41;
         6'o50: t = 6'd51;  6'o51: t = 6'd19;  6'o52: t = 6'd59;  6'o53: t = 6'd27;
         6'o54: t = 6'd49;  6'o55: t = 6'd17;  6'o56: t = 6'd57;  6'o57: t = 6'd25;
         6'o60: t = 6'd15;  6'o61: t = 6'd47;  6'o62: t = 6'd7;   6'o63: t = 6'd39;
         6'o64: t = 6'd13;  6'o65: t = 6'd45;  6'o66: t = 6'd5;   6'o67: t = 6'd37;
         6'o70: t = 6'd63;  6'o71: t = 6'd31;  6'o72: t = 6'd55;  6'o73: t = 6'd23;
         6'o74: t = 6'd61;  6'o75: t = 6'd29;  6'o76: t = 6'd53;  default: t = 6'd21;
      endcase
      return {t, 2'b00};
   endfunction

   // Rain intensity of one RGB565 pixel, 0 when it is not a rain color.
   // The divisions by 115 and 95 use reciprocal multiplies with a 20-bit
   // shift; the operands stay small enough that the result is exact.
   function automatic logic [7:0] rain_intensity(input logic [PIX_W-1:0] px);
      logic [7:0]  r, g, b, mx, mn, v;
      logic [8:0]  avg;
      logic        ground, rain;
      logic [6:0]  x1, x2, x3, x4;
      logic [26:0] q1, q3;
      logic [9:0]  q2;
      logic [15:0] q4;
      r  = {px[15:11], 3'b000};
      g  = {px[10:5], 2'b00};
      b  = {px[4:0], 3'b000};
      mx = (r > g) ? r : g;
      mn = (r < g) ? r : g;
      if (b > mx) mx = b;
      if (b < mn) mn = b;

      ground = (8'(mx - mn) < 8'd60) ||
               (r > 8'd100 && g > 8'd80 && b < 8'd150 && abs_diff(r, g) < 8'd50);
      rain = !ground &&
             ((b > g && g > r && b > 8'd180) ||
              (r < 8'd30 && g > 8'd120 && b > 8'd120 && abs_diff(g, b) < 8'd50) ||
              (r < 8'd50 && g > 8'd80 && g < 8'd160 && b > 8'd70 && b < 8'd150) ||
              (r < 8'd50 && g > 8'd150 && b < 8'd110) ||
              (r > 8'd140 && r > g && r > b));

      avg = 9'((9'(g) + 9'(b)) >> 1);
      x1  = 7'(avg - 9'd140);
      q1  = 27'(x1) * 27'd638330;
      x2  = 7'(g - 8'd80);
      q2  = 10'(x2) * 10'd5;
      x3  = 7'(g - 8'd160);
      q3  = 27'(x3) * 27'd772660;
      x4  = 7'(r - 8'd150);
      q4  = 16'(x4) * 16'd342;

      v = 8'd0;
      if (rain && px != 16'h0000) begin
         if (r < 8'd50 && g > 8'd140 && b > 8'd140 && abs_diff(g, b) < 8'd40) begin
            v = 8'(q1 >> 20) + 8'd30;
         end else if (r < 8'd60 && g > 8'd80 && g < 8'd160 && b > 8'd70 && b < 8'd150) begin
            v = 8'(q2 >> 3) + 8'd100;
         end else if (r < 8'd60 && g > 8'd160 && b < 8'd120) begin
            v = 8'(q3 >> 20) + 8'd150;
         end else if (r > 8'd150) begin
            v = 8'(q4 >> 10) + 8'd220;
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

/* src/rain_color_ordered_dither.sv */
`timescale 1ns / 1ps
`default_nettype none
// A pixel word accepted into the input register is classified and dithered there, and a byte
// it completes is registered in the result register and offered on rsp_. Throughput: one pixel
// word per clock, set by the single pass from input to result register, unless rsp_stall holds a byte.
// Synchronous active-high reset clears frame position, bit accumulator and totals,
// empties both registers and sets image_size to 128.
module rain_color_ordered_dither #(
   parameter int MAX_SIZE = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [rcod_pkg::PIX_W-1:0]  req_pixel,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [rcod_pkg::BYTE_W-1:0]      rsp_bitmap_byte,
   output logic                             rsp_frame_last,
   output logic [rcod_pkg::SUM_W-1:0]       rsp_rain_sum,
   output logic [rcod_pkg::CNT_W-1:0]       rsp_rain_count,
   input  wire logic                        csr_wr_en,
   input  wire logic [rcod_pkg::SIZE_W-1:0] csr_wr_data
);
   import rcod_pkg::*;

   localparam int POS_W = $clog2(MAX_SIZE);
   localparam int SZ_W  = $clog2(MAX_SIZE + 1);
   localparam int CMP_W = ((SZ_W > SIZE_W) ? SZ_W : SIZE_W) + 1;

   logic [SIZE_W-1:0] image_size_ff, image_size_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]  s1_pixel_ff, s1_pixel_in;
   logic [POS_W-1:0]  column_ff, column_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [7:0]        bit_accum_ff, bit_accum_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic [SUM_W-1:0]  out_sum_ff, out_sum_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;

   logic [CMP_W-1:0]  size_eff;
   logic              row_end, frame_end, emit, s1_go, req_take;
   logic [7:0]        inten, bit_next;
   logic [SUM_W-1:0]  total_next;
   logic [CNT_W-1:0]  count_next;

   always_comb begin
      size_eff = CMP_W'(image_size_ff);
      if (size_eff == '0) size_eff = CMP_W'(1);
      if (size_eff > CMP_W'(MAX_SIZE)) size_eff = CMP_W'(MAX_SIZE);

      row_end   = (CMP_W'(column_ff) + CMP_W'(1)) >= size_eff;
      frame_end = row_end && ((CMP_W'(row_ff) + CMP_W'(1)) >= size_eff);
      emit      = row_end || (column_ff[2:0] == 3'd7);

      // The word in the input register moves on unless it completes a byte
      // and the result register is still held.
      s1_go     = s1_valid_ff && (!emit || !out_valid_ff || !rsp_stall);
      req_stall = s1_valid_ff && !s1_go;
      req_take  = req_valid && !req_stall;

      inten    = rain_intensity(s1_pixel_ff);
      bit_next = bit_accum_ff;
      if (inten > bayer_threshold(row_ff[2:0], column_ff[2:0])) begin
         bit_next = bit_accum_ff | (8'h80 >> column_ff[2:0]);
      end

      total_next = total_ff;
      count_next = count_ff;
      if (inten != 8'd0) begin
         total_next = (total_ff > SUM_MAX - SUM_W'(inten)) ? SUM_MAX
                                                          : total_ff + SUM_W'(inten);
         if (count_ff != CNT_MAX) count_next = count_ff + CNT_W'(1);
      end

      image_size_in = csr_wr_en ? csr_wr_data : image_size_ff;

      s1_pixel_in = req_take ? req_pixel : s1_pixel_ff;
      s1_valid_in = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

      column_in    = column_ff;
      row_in       = row_ff;
      bit_accum_in = bit_accum_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_sum_in   = out_sum_ff;
      out_count_in = out_count_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      if (s1_go) begin
         if (!emit) begin
            column_in    = column_ff + POS_W'(1);
            bit_accum_in = bit_next;
            total_in     = total_next;
            count_in     = count_next;
         end else begin
            out_valid_in = 1'b1;
            out_byte_in  = bit_next;
            out_last_in  = frame_end;
            out_sum_in   = frame_end ? total_next : '0;
            out_count_in = frame_end ? count_next : '0;
            bit_accum_in = 8'd0;
            if (frame_end) begin
               column_in = '0;
               row_in    = '0;
               total_in  = '0;
               count_in  = '0;
            end else if (row_end) begin
               column_in = '0;
               row_in    = row_ff + POS_W'(1);
               total_in  = total_next;
               count_in  = count_next;
            end else begin
               column_in = column_ff + POS_W'(1);
               total_in  = total_next;
               count_in  = count_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= SIZE_RESET;
         s1_valid_ff   <= 1'b0;
         column_ff     <= '0;
         row_ff        <= '0;
         bit_accum_ff  <= 8'd0;
         total_ff      <= '0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         image_size_ff <= image_size_in;
         s1_valid_ff   <= s1_valid_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         bit_accum_ff  <= bit_accum_in;
         total_ff      <= total_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff  <= s1_pixel_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_sum_ff   <= out_sum_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bitmap_byte = out_byte_ff;
   assign rsp_frame_last  = out_last_ff;
   assign rsp_rain_sum    = out_sum_ff;
   assign rsp_rain_count  = out_count_ff;

endmodule

`default_nettype wire
